@@ src/rgbhsv_pkg.sv @@
// rgbhsv_pkg: widths, item types and sector codes for the rgb to hsv pixel core
// used by rgb_to_hsv_pixel_core; depends on nothing
package rgbhsv_pkg;

  localparam int unsigned CHANNEL_BITS = 8;
  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned HUE_DEN_BITS = CHANNEL_BITS + 3;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [FRAC_BITS-1:0]    hue;
    logic [FRAC_BITS-1:0]    saturation;
    logic [CHANNEL_BITS-1:0] brightness;
  } result_t;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_e;

  typedef struct packed {
    logic                    valid;
    logic [CHANNEL_BITS-1:0] brightness;
    logic                    hue_zero;
    logic                    sat_zero;
    logic                    sat_full;
  } side_t;

endpackage

@@ src/rgbhsv_frac_div.sv @@
// rgbhsv_frac_div: pipelined restoring divider, one quotient bit per stage
// gives floor(num * 2^Q_W / den) for num < den; no package or module dependencies
module rgbhsv_frac_div #(
  parameter int unsigned DEN_W = 8,
  parameter int unsigned Q_W   = 16
) (
  input  logic             clk_i,
  input  logic [DEN_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [Q_W-1:0]   quot_o
);

  logic [DEN_W-1:0] rem_q  [Q_W-1];
  logic [DEN_W-1:0] den_q  [Q_W-1];
  logic [Q_W-1:0]   quot_q [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   q_in;
    logic [DEN_W:0]   dbl;
    logic [DEN_W:0]   diff;
    logic             take;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign q_in   = quot_q[k-1];
    end

    assign dbl  = {rem_in, 1'b0};
    assign diff = dbl - {1'b0, den_in};
    assign take = (dbl >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      quot_q[k] <= {q_in[Q_W-2:0], take};
    end

    if (k < Q_W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        rem_q[k] <= take ? diff[DEN_W-1:0] : dbl[DEN_W-1:0];
        den_q[k] <= den_in;
      end
    end
  end

  assign quot_o = quot_q[Q_W-1];

endmodule

@@ src/rgb_to_hsv_pixel_core.sv @@
// rgb_to_hsv_pixel_core: top level, rgb pixel in, hue / saturation / brightness out
// the path is registered through the front stages, the divider stages and the output register; one item per cycle
// throughput is set by the one-bit-per-stage divider pipelines, which take a new item each cycle
// busy is always low; each result shows for one cycle with valid_o and cannot be held off
// asynchronous active-low reset clears all valid bits and side flags; datapath is not reset
// depends on rgbhsv_pkg and rgbhsv_frac_div
module rgb_to_hsv_pixel_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  rgbhsv_pkg::pixel_t  pixel_i,
  output logic                valid_o,
  output rgbhsv_pkg::result_t result_o
);
  import rgbhsv_pkg::*;

  localparam int unsigned LATENCY = FRAC_BITS + 4;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // stage 1: max, min, sector, signed difference
  logic [CHANNEL_BITS-1:0] v_d, m_d, v1_q, m1_q;
  logic signed [CHANNEL_BITS:0] diff_d, diff1_q;
  sector_e sec_d, sec1_q;
  logic valid1_q;

  always_comb begin
    if (pixel_i.red >= pixel_i.green && pixel_i.red >= pixel_i.blue) begin
      sec_d  = SEC_RED;
      v_d    = pixel_i.red;
      diff_d = $signed({1'b0, pixel_i.green}) - $signed({1'b0, pixel_i.blue});
    end else if (pixel_i.green >= pixel_i.blue) begin
      sec_d  = SEC_GREEN;
      v_d    = pixel_i.green;
      diff_d = $signed({1'b0, pixel_i.blue}) - $signed({1'b0, pixel_i.red});
    end else begin
      sec_d  = SEC_BLUE;
      v_d    = pixel_i.blue;
      diff_d = $signed({1'b0, pixel_i.red}) - $signed({1'b0, pixel_i.green});
    end
    if (pixel_i.red <= pixel_i.green && pixel_i.red <= pixel_i.blue) begin
      m_d = pixel_i.red;
    end else if (pixel_i.green <= pixel_i.blue) begin
      m_d = pixel_i.green;
    end else begin
      m_d = pixel_i.blue;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
    end else begin
      valid1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    v1_q    <= v_d;
    m1_q    <= m_d;
    diff1_q <= diff_d;
    sec1_q  <= sec_d;
  end

  // stage 2: chroma
  logic [CHANNEL_BITS-1:0] c2_q, v2_q;
  logic signed [CHANNEL_BITS:0] diff2_q;
  sector_e sec2_q;
  logic valid2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid2_q <= 1'b0;
    end else begin
      valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c2_q    <= v1_q - m1_q;
    v2_q    <= v1_q;
    diff2_q <= diff1_q;
    sec2_q  <= sec1_q;
  end

  // stage 3: hue numerator and denominator, special-case flags
  logic [HUE_DEN_BITS-1:0] c_ext, six_c, base_d, diff_ext, hnum_d;
  logic [HUE_DEN_BITS-1:0] hnum3_q, hden3_q;
  logic [CHANNEL_BITS-1:0] snum3_q, sden3_q;
  side_t side_d, side3_q;

  always_comb begin
    c_ext    = HUE_DEN_BITS'(c2_q);
    six_c    = (c_ext << 2) + (c_ext << 1);
    diff_ext = HUE_DEN_BITS'(diff2_q);
    case (sec2_q)
      SEC_RED:   base_d = diff2_q[CHANNEL_BITS] ? six_c : '0;
      SEC_GREEN: base_d = c_ext << 1;
      SEC_BLUE:  base_d = c_ext << 2;
      default:   base_d = '0;
    endcase
    hnum_d = base_d + diff_ext;

    side_d.valid      = valid2_q;
    side_d.brightness = v2_q;
    side_d.hue_zero   = (c2_q == '0);
    side_d.sat_zero   = (v2_q == '0);
    side_d.sat_full   = (c2_q == v2_q) && (v2_q != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side3_q <= '0;
    end else begin
      side3_q <= side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hnum3_q <= hnum_d;
    hden3_q <= six_c;
    snum3_q <= c2_q;
    sden3_q <= v2_q;
  end

  // divider stages
  logic [FRAC_BITS-1:0] hue_quot, sat_quot;

  rgbhsv_frac_div #(
    .DEN_W (HUE_DEN_BITS),
    .Q_W   (FRAC_BITS)
  ) u_hue_div (
    .clk_i  (clk_i),
    .num_i  (hnum3_q),
    .den_i  (hden3_q),
    .quot_o (hue_quot)
  );

  rgbhsv_frac_div #(
    .DEN_W (CHANNEL_BITS),
    .Q_W   (FRAC_BITS)
  ) u_sat_div (
    .clk_i  (clk_i),
    .num_i  (snum3_q),
    .den_i  (sden3_q),
    .quot_o (sat_quot)
  );

  side_t side_q [FRAC_BITS];

  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_side
    side_t side_in;
    if (k == 0) begin : g_first
      assign side_in = side3_q;
    end else begin : g_next
      assign side_in = side_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[k] <= '0;
      end else begin
        side_q[k] <= side_in;
      end
    end
  end

  // output register
  side_t   side_out;
  result_t result_d, result_q;
  logic    valid_q;

  always_comb begin
    side_out            = side_q[FRAC_BITS-1];
    result_d.brightness = side_out.brightness;
    result_d.hue        = side_out.hue_zero ? '0 : hue_quot;
    if (side_out.sat_zero) begin
      result_d.saturation = '0;
    end else if (side_out.sat_full) begin
      result_d.saturation = '1;
    end else begin
      result_d.saturation = sat_quot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= side_out.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

`ifndef SYNTH
  a_black_unsaturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && result_o.brightness == '0 |-> result_o.saturation == '0)
    else $error("black pixel with non-zero saturation");

  a_gray_no_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && result_o.saturation == '0 |-> result_o.hue == '0)
    else $error("gray pixel with non-zero hue");

  a_result_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(accept, LATENCY))
    else $error("result without an accepted item");

  a_item_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LATENCY valid_o)
    else $error("accepted item lost in the pipeline");
`endif

endmodule

@@ verif/hsv_checker.sv @@
`timescale 1ns / 100ps
// hsv_checker: watches the pixel and result channels of rgb_to_hsv_pixel_core,
// predicts hue, saturation and brightness for each accepted item and compares them
// depends on rgbhsv_pkg
module hsv_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  rgbhsv_pkg::pixel_t  pixel_i,
  input  logic                valid_i,
  input  rgbhsv_pkg::result_t result_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);
  import rgbhsv_pkg::*;

  localparam longint unsigned FRAC_MAX = (64'd1 << FRAC_BITS) - 1;

  result_t expected_hsv_q[$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic result_t hsv_from_rgb(pixel_t px);
    longint unsigned r, g, b, top, bottom, chroma, numer, denom, frac;
    sector_e         sector;
    result_t         res;
    r      = 64'(px.red);
    g      = 64'(px.green);
    b      = 64'(px.blue);
    top    = r;
    sector = SEC_RED;
    if (g > top) begin
      top    = g;
      sector = SEC_GREEN;
    end
    if (b > top) begin
      top    = b;
      sector = SEC_BLUE;
    end
    bottom = r;
    if (g < bottom) bottom = g;
    if (b < bottom) bottom = b;
    chroma = top - bottom;

    res.brightness = top[CHANNEL_BITS-1:0];
    res.saturation = '0;
    res.hue        = '0;

    if (top != 0) begin
      frac = (chroma << FRAC_BITS) / top;
      if (frac > FRAC_MAX) frac = FRAC_MAX;
      res.saturation = frac[FRAC_BITS-1:0];
    end

    if (chroma != 0) begin
      denom = 6 * chroma;
      case (sector)
        SEC_RED: begin
          numer = denom + g - b;
          if (numer >= denom) numer = numer - denom;
        end
        SEC_GREEN: begin
          numer = 2 * chroma + b - r;
        end
        default: begin
          numer = 4 * chroma + r - g;
        end
      endcase
      frac = (numer << FRAC_BITS) / denom;
      if (frac > FRAC_MAX) frac = FRAC_MAX;
      res.hue = frac[FRAC_BITS-1:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
    $display("%0t ns hsv %s: expected %0d got %0d", $time, what, want, got);
    fail_count_o++;
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (start_i && !busy_i) expected_hsv_q.push_back(hsv_from_rgb(pixel_i));
      if (valid_i) begin
        if (expected_hsv_q.size() == 0) begin
          report_mismatch("result with no item waiting", 64'd0, 64'(result_i));
        end else begin
          want = expected_hsv_q.pop_front();
          if (result_i.hue != want.hue)
            report_mismatch("hue", 64'(want.hue), 64'(result_i.hue));
          if (result_i.saturation != want.saturation)
            report_mismatch("saturation", 64'(want.saturation), 64'(result_i.saturation));
          if (result_i.brightness != want.brightness)
            report_mismatch("brightness", 64'(want.brightness), 64'(result_i.brightness));
        end
      end
      pending_o <= unsigned'(expected_hsv_q.size());
    end
  end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// tb_top: drives rgb pixels into rgb_to_hsv_pixel_core with random gaps and
// gives the verdict from the failure and pending counts of hsv_checker
// depends on rgbhsv_pkg, rgb_to_hsv_pixel_core and hsv_checker
module tb_top;
  import rgbhsv_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 400;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned PIXEL_BITS   = 3 * CHANNEL_BITS;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  pixel_t      pixel_i;
  logic        valid_o;
  result_t     result_o;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  int unsigned item_no = 0;

  logic [PIXEL_BITS-1:0] corner_px[23] = '{
    24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101, 24'hFF0000, 24'h00FF00,
    24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'hFF0001, 24'hC80A32,
    24'h0AC805, 24'h1E14C8, 24'hFF0080, 24'h010000, 24'h000100, 24'h000001,
    24'h010100, 24'hFEFFFD, 24'hFFFEFF, 24'h7F8080, 24'h80807F
  };

  always #1 clk_i = ~clk_i;

  rgb_to_hsv_pixel_core u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .pixel_i  (pixel_i),
    .valid_o  (valid_o),
    .result_o (result_o)
  );

  hsv_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .pixel_i      (pixel_i),
    .valid_i      (valid_o),
    .result_i     (result_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // sender gap rate changes over the run: light, heavy, none
  task automatic send_pixel(pixel_t px);
    int unsigned gap_pct;
    gap_pct = (item_no < 140) ? 16 : (item_no < 280) ? 77 : 0;
    while ($urandom_range(99) < gap_pct) begin
      start   <= 1'b0;
      pixel_i <= pixel_t'(PIXEL_BITS'($urandom));
      @(posedge clk_i);
    end
    start   <= 1'b1;
    pixel_i <= px;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    item_no++;
  endtask

  initial begin
    pixel_t                  px;
    logic [CHANNEL_BITS-1:0] a, b;
    start   <= 1'b0;
    pixel_i <= '0;
    rst_ni  <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (corner_px[i]) send_pixel(pixel_t'(corner_px[i]));

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: begin
          px = pixel_t'(PIXEL_BITS'($urandom));
        end
        6, 7: begin
          // near grey, small chroma
          a        = CHANNEL_BITS'($urandom_range(255));
          px.red   = a ^ CHANNEL_BITS'($urandom_range(3));
          px.green = a ^ CHANNEL_BITS'($urandom_range(3));
          px.blue  = a ^ CHANNEL_BITS'($urandom_range(3));
        end
        8: begin
          // two channels tied
          a = CHANNEL_BITS'($urandom_range(255));
          b = CHANNEL_BITS'($urandom_range(255));
          case ($urandom_range(2))
            0:       px = '{a, a, b};
            1:       px = '{a, b, a};
            default: px = '{b, a, a};
          endcase
        end
        default: begin
          // channels at or next to the rails
          px.red   = $urandom_range(1) ? ~CHANNEL_BITS'($urandom_range(1))
                                       : CHANNEL_BITS'($urandom_range(1));
          px.green = $urandom_range(1) ? ~CHANNEL_BITS'($urandom_range(1))
                                       : CHANNEL_BITS'($urandom_range(1));
          px.blue  = $urandom_range(1) ? ~CHANNEL_BITS'($urandom_range(1))
                                       : CHANNEL_BITS'($urandom_range(1));
        end
      endcase
      send_pixel(px);
    end
    start <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
